[rtl/core/fixed_block_pool_allocator_defines.svh]
// assertion helpers used by the block pool allocator
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// same-cycle implication, idle under reset
`define FBPA_ASSERT_IMP(label, clk_i, rst_n_i, cond_a, cond_b, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) \
		(cond_a) |-> (cond_b)) else $error(msg);

// next-cycle implication, idle under reset
`define FBPA_ASSERT_NXT(label, clk_i, rst_n_i, cond_a, cond_b, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) \
		(cond_a) |=> (cond_b)) else $error(msg);

`endif

[rtl/core/fbpa_pkg.sv]
`default_nettype none

package fbpa_pkg;

	localparam int ADDR_W    = 32;
	localparam int FC_W      = 11;
	localparam int STATUS_W  = 3;
	localparam int CMD_W     = 2;
	localparam int M_TDATA_W = 48;
	localparam int PAD_W     = M_TDATA_W - FC_W - ADDR_W;
	localparam int DIV_STEPS = 32;
	localparam int STEP_W    = 5;
	localparam int APB_AW    = 4;

	localparam logic [ADDR_W-1:0] ALIGN_DEFAULT = 32'd4;
	localparam logic [ADDR_W-1:0] ALIGN_ODD     = 32'd2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT  = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_FREE  = 2'd2,
		CMD_RSVD  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK      = 3'd0,
		STS_INVALID = 3'd1,
		STS_EMPTY   = 3'd2,
		STS_FULL    = 3'd3,
		STS_NOPOOL  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_CHUNK_BASE  = 2'd0,
		REG_CHUNK_BYTES = 2'd1,
		REG_BLOCK_BYTES = 2'd2,
		REG_ALIGNMENT   = 2'd3
	} reg_idx_t;

endpackage

`default_nettype wire

[rtl/core/fbpa_ram.sv]
`default_nettype none

module fbpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/fixed_block_pool_allocator.sv]
// free and failed commands: result registered at the accepting edge
// allocate: the stack memory read is registered, then the result in ST_POP
// init: ST_DIV then ST_FILL; a shared 34-bit adder does the
// 32 restoring-division steps and then one stack write per cycle for the fill
// reset: asynchronous, clears registers, count and pool flag; stack contents undefined
`default_nettype none
`include "fixed_block_pool_allocator_defines.svh"

module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// apb configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fbpa_pkg::APB_AW-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	// command stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [31:0]                   s_tdata,  // [31:0] block_address
	input  wire logic [fbpa_pkg::CMD_W-1:0]    s_tuser,  // [1:0] command
	// result stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [fbpa_pkg::M_TDATA_W-1:0]     m_tdata,  // [31:0] allocated_address,
	                                                     // [42:32] free_count, rest zero
	output logic [fbpa_pkg::STATUS_W-1:0]      m_tuser   // [2:0] status
);

	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int AD = fbpa_pkg::ADDR_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FILL,
		ST_POP
	} state_t;

	state_t state_q;

	logic [AD-1:0] base_q, bytes_q, blk_q, align_q;
	logic [CW-1:0] count_q;
	logic          pool_valid_q;

	logic [AD-1:0]                 rem_q, quo_q;
	logic [fbpa_pkg::STEP_W-1:0]   step_q;
	logic [CW-1:0]                 fill_n_q, fill_idx_q;
	logic [AD-1:0]                 fill_addr_q;

	logic                          m_tvalid_q;
	fbpa_pkg::status_t             out_status_q;
	logic [AD-1:0]                 out_addr_q;
	logic [fbpa_pkg::FC_W-1:0]     out_count_q;

	// apb
	logic              cfg_we;
	fbpa_pkg::reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_idx = fbpa_pkg::reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (cfg_idx)
			fbpa_pkg::REG_CHUNK_BASE:  prdata = base_q;
			fbpa_pkg::REG_CHUNK_BYTES: prdata = bytes_q;
			fbpa_pkg::REG_BLOCK_BYTES: prdata = blk_q;
			fbpa_pkg::REG_ALIGNMENT:   prdata = align_q;
			default:                   prdata = '0;
		endcase
	end

	// input side
	logic         s_accept;
	fbpa_pkg::cmd_t cmd;
	logic [AD-1:0] align_eff;
	logic         init_ok, in_range, full;
	logic [AD:0]  limit;
	logic [CW-1:0] count_m1;

	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign s_accept = s_tvalid && s_tready;
	assign cmd      = fbpa_pkg::cmd_t'(s_tuser);

	assign align_eff = (align_q == '0 || align_q == fbpa_pkg::ALIGN_ODD) ?
		fbpa_pkg::ALIGN_DEFAULT : align_q;
	assign init_ok   = (blk_q != '0) && (blk_q <= bytes_q) &&
		((align_eff & (align_eff - 1'b1)) == '0) && (base_q[2:0] == 3'd0);

	// sum kept 33 bits wide so the top of the chunk does not wrap
	assign limit    = {1'b0, base_q} + {1'b0, bytes_q};
	assign in_range = (s_tdata >= base_q) && ({1'b0, s_tdata} < limit);
	assign full     = (count_q >= CW'(MAX_BLOCKS));
	assign count_m1 = count_q - CW'(1);

	// shared adder: divider subtract step, then fill address increment
	logic [AD+1:0] op_a, op_b, sum;
	logic          op_sub;

	always_comb begin
		if (state_q == ST_DIV) begin
			op_a   = {1'b0, rem_q, quo_q[AD-1]};
			op_b   = {2'b00, blk_q};
			op_sub = 1'b1;
		end else begin
			op_a   = {2'b00, fill_addr_q};
			op_b   = {2'b00, blk_q};
			op_sub = 1'b0;
		end
		sum = op_a + (op_sub ? ~op_b : op_b) + (AD+2)'(op_sub);
	end

	logic          div_ge;
	logic [AD-1:0] rem_next, quo_next;
	logic [CW-1:0] blocks_n;

	assign div_ge   = !sum[AD+1];
	assign rem_next = div_ge ? sum[AD-1:0] : op_a[AD-1:0];
	assign quo_next = {quo_q[AD-2:0], div_ge};
	assign blocks_n = (quo_next > AD'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(quo_next);

	// stack memory
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [AD-1:0] ram_wdata, ram_rdata;
	logic          fill_busy;

	assign fill_busy = (state_q == ST_FILL) && (fill_idx_q != fill_n_q);
	assign ram_we    = fill_busy || (s_accept && cmd == fbpa_pkg::CMD_FREE &&
		pool_valid_q && in_range && !full);
	assign ram_waddr = (state_q == ST_FILL) ? fill_idx_q[AW-1:0] : count_q[AW-1:0];
	assign ram_wdata = (state_q == ST_FILL) ? fill_addr_q : s_tdata;
	assign ram_re    = s_accept && cmd == fbpa_pkg::CMD_ALLOC && pool_valid_q &&
		count_q != '0;
	assign ram_raddr = count_m1[AW-1:0];

	fbpa_ram #(
		.WIDTH(AD),
		.DEPTH(MAX_BLOCKS)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			bytes_q      <= '0;
			blk_q        <= '0;
			align_q      <= '0;
			state_q      <= ST_IDLE;
			count_q      <= '0;
			pool_valid_q <= 1'b0;
			rem_q        <= '0;
			quo_q        <= '0;
			step_q       <= '0;
			fill_n_q     <= '0;
			fill_idx_q   <= '0;
			fill_addr_q  <= '0;
			m_tvalid_q   <= 1'b0;
			out_status_q <= fbpa_pkg::STS_OK;
			out_addr_q   <= '0;
			out_count_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					fbpa_pkg::REG_CHUNK_BASE:  base_q  <= pwdata;
					fbpa_pkg::REG_CHUNK_BYTES: bytes_q <= pwdata;
					fbpa_pkg::REG_BLOCK_BYTES: blk_q   <= pwdata;
					fbpa_pkg::REG_ALIGNMENT:   align_q <= pwdata;
					default: ;
				endcase
			end

			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						out_addr_q <= '0;
						unique case (cmd)
							fbpa_pkg::CMD_INIT: begin
								if (init_ok) begin
									state_q <= ST_DIV;
									rem_q   <= '0;
									quo_q   <= bytes_q;
									step_q  <= '0;
								end else begin
									m_tvalid_q   <= 1'b1;
									out_status_q <= fbpa_pkg::STS_INVALID;
									out_count_q  <= fbpa_pkg::FC_W'(count_q);
								end
							end
							fbpa_pkg::CMD_ALLOC: begin
								if (!pool_valid_q) begin
									m_tvalid_q   <= 1'b1;
									out_status_q <= fbpa_pkg::STS_NOPOOL;
									out_count_q  <= fbpa_pkg::FC_W'(count_q);
								end else if (count_q == '0) begin
									m_tvalid_q   <= 1'b1;
									out_status_q <= fbpa_pkg::STS_EMPTY;
									out_count_q  <= fbpa_pkg::FC_W'(count_q);
								end else begin
									count_q <= count_m1;
									state_q <= ST_POP;
								end
							end
							fbpa_pkg::CMD_FREE: begin
								m_tvalid_q <= 1'b1;
								if (!pool_valid_q) begin
									out_status_q <= fbpa_pkg::STS_NOPOOL;
									out_count_q  <= fbpa_pkg::FC_W'(count_q);
								end else if (!in_range) begin
									out_status_q <= fbpa_pkg::STS_INVALID;
									out_count_q  <= fbpa_pkg::FC_W'(count_q);
								end else if (full) begin
									out_status_q <= fbpa_pkg::STS_FULL;
									out_count_q  <= fbpa_pkg::FC_W'(count_q);
								end else begin
									count_q      <= count_q + CW'(1);
									out_status_q <= fbpa_pkg::STS_OK;
									out_count_q  <= fbpa_pkg::FC_W'(count_q + CW'(1));
								end
							end
							default: begin
								m_tvalid_q   <= 1'b1;
								out_status_q <= fbpa_pkg::STS_INVALID;
								out_count_q  <= fbpa_pkg::FC_W'(count_q);
							end
						endcase
					end
				end
				ST_DIV: begin
					rem_q  <= rem_next;
					quo_q  <= quo_next;
					step_q <= step_q + 1'b1;
					if (step_q == fbpa_pkg::STEP_W'(fbpa_pkg::DIV_STEPS - 1)) begin
						state_q     <= ST_FILL;
						fill_n_q    <= blocks_n;
						fill_idx_q  <= '0;
						fill_addr_q <= base_q;
					end
				end
				ST_FILL: begin
					if (fill_busy) begin
						fill_idx_q  <= fill_idx_q + CW'(1);
						fill_addr_q <= sum[AD-1:0];
					end else begin
						state_q      <= ST_IDLE;
						count_q      <= fill_n_q;
						pool_valid_q <= 1'b1;
						m_tvalid_q   <= 1'b1;
						out_status_q <= fbpa_pkg::STS_OK;
						out_count_q  <= fbpa_pkg::FC_W'(fill_n_q);
					end
				end
				ST_POP: begin
					state_q      <= ST_IDLE;
					m_tvalid_q   <= 1'b1;
					out_status_q <= fbpa_pkg::STS_OK;
					out_addr_q   <= ram_rdata;
					out_count_q  <= fbpa_pkg::FC_W'(count_q);
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{fbpa_pkg::PAD_W{1'b0}}, out_count_q, out_addr_q};

	`FBPA_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(MAX_BLOCKS), "stack count above depth")
	`FBPA_ASSERT_IMP(a_busy_not_ready, clk, arst_n, state_q != ST_IDLE, !s_tready, "ready while sequencer busy")
	`FBPA_ASSERT_IMP(a_no_pool_empty, clk, arst_n, !pool_valid_q, count_q == '0, "blocks held without a pool")
	`FBPA_ASSERT_NXT(a_pop_result, clk, arst_n, state_q == ST_POP, m_tvalid && state_q == ST_IDLE, "pop gave no result")

endmodule

`default_nettype wire

[tb/fixed_block_pool_allocator_tb.sv]
`timescale 1ns / 1ps

module fixed_block_pool_allocator_tb;

	localparam int POOL_DEPTH  = 1024;
	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 40;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 124;

	typedef struct packed {
		fbpa_pkg::cmd_t              cmd;
		fbpa_pkg::status_t           status;
		logic [fbpa_pkg::ADDR_W-1:0] addr;
		logic [fbpa_pkg::FC_W-1:0]   free_count;
	} pool_result_t;

	// mirror of the pool: registers, free stack and the results still owed
	class block_pool_mirror;
		logic [31:0]  chunk_base;
		logic [31:0]  chunk_bytes;
		logic [31:0]  block_bytes;
		logic [31:0]  alignment;
		logic [31:0]  stack_mem [POOL_DEPTH];
		int unsigned  depth_used;
		bit           pool_up;
		pool_result_t pending_results[$];
		logic [31:0]  handed_out[$];
		int           mismatches;

		function new();
			chunk_base  = '0;
			chunk_bytes = '0;
			block_bytes = '0;
			alignment   = '0;
			depth_used  = 0;
			pool_up     = 1'b0;
			mismatches  = 0;
		endfunction

		function void write_reg(fbpa_pkg::reg_idx_t idx, logic [31:0] val);
			case (idx)
				fbpa_pkg::REG_CHUNK_BASE:  chunk_base  = val;
				fbpa_pkg::REG_CHUNK_BYTES: chunk_bytes = val;
				fbpa_pkg::REG_BLOCK_BYTES: block_bytes = val;
				fbpa_pkg::REG_ALIGNMENT:   alignment   = val;
				default: ;
			endcase
		endfunction

		function fbpa_pkg::status_t build_pool();
			logic [31:0] align;
			logic [31:0] next_addr;
			int unsigned blocks;
			if (block_bytes == '0 || block_bytes > chunk_bytes)
				return fbpa_pkg::STS_INVALID;
			align = alignment;
			if (align == '0 || align == fbpa_pkg::ALIGN_ODD)
				align = fbpa_pkg::ALIGN_DEFAULT;
			if ((align & (align - 32'd1)) != '0)
				return fbpa_pkg::STS_INVALID;
			if (chunk_base[2:0] != 3'd0)
				return fbpa_pkg::STS_INVALID;
			blocks = chunk_bytes / block_bytes;
			if (blocks > POOL_DEPTH)
				blocks = POOL_DEPTH;
			// addresses wrap at 32 bits
			next_addr = chunk_base;
			for (int i = 0; i < blocks; i++) begin
				stack_mem[i] = next_addr;
				next_addr = next_addr + block_bytes;
			end
			depth_used = blocks;
			pool_up = 1'b1;
			return fbpa_pkg::STS_OK;
		endfunction

		function void take_command(fbpa_pkg::cmd_t cmd, logic [31:0] addr);
			pool_result_t r;
			logic [32:0]  limit;
			r.cmd = cmd;
			r.addr = '0;
			case (cmd)
				fbpa_pkg::CMD_INIT: r.status = build_pool();
				fbpa_pkg::CMD_ALLOC: begin
					if (!pool_up) begin
						r.status = fbpa_pkg::STS_NOPOOL;
					end else if (depth_used == 0) begin
						r.status = fbpa_pkg::STS_EMPTY;
					end else begin
						depth_used--;
						r.addr = stack_mem[depth_used];
						r.status = fbpa_pkg::STS_OK;
					end
				end
				fbpa_pkg::CMD_FREE: begin
					// upper bound taken without wrap
					limit = {1'b0, chunk_base} + {1'b0, chunk_bytes};
					if (!pool_up) begin
						r.status = fbpa_pkg::STS_NOPOOL;
					end else if (addr < chunk_base || {1'b0, addr} >= limit) begin
						r.status = fbpa_pkg::STS_INVALID;
					end else if (depth_used >= POOL_DEPTH) begin
						r.status = fbpa_pkg::STS_FULL;
					end else begin
						stack_mem[depth_used] = addr;
						depth_used++;
						r.status = fbpa_pkg::STS_OK;
					end
				end
				default: r.status = fbpa_pkg::STS_INVALID;
			endcase
			r.free_count = fbpa_pkg::FC_W'(depth_used);
			pending_results = {pending_results, r};
		endfunction

		task flag_mismatch(string msg);
			if (mismatches < 100)
				$display("%0t mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		task match_result(logic [fbpa_pkg::STATUS_W-1:0] sts,
				logic [fbpa_pkg::M_TDATA_W-1:0] data);
			pool_result_t                want;
			logic [fbpa_pkg::ADDR_W-1:0] got_addr;
			logic [fbpa_pkg::FC_W-1:0]   got_fc;
			got_addr = data[fbpa_pkg::ADDR_W-1:0];
			got_fc = data[fbpa_pkg::ADDR_W +: fbpa_pkg::FC_W];
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result status %0d addr %h count %0d",
					sts, got_addr, got_fc));
				return;
			end
			want = pending_results.pop_front();
			if (sts !== want.status)
				flag_mismatch($sformatf("%s status %0d, want %0d",
					want.cmd.name(), sts, want.status));
			if (got_addr !== want.addr)
				flag_mismatch($sformatf("%s address %h, want %h",
					want.cmd.name(), got_addr, want.addr));
			if (got_fc !== want.free_count)
				flag_mismatch($sformatf("%s free count %0d, want %0d",
					want.cmd.name(), got_fc, want.free_count));
			// keep some handed-out blocks so the stimulus can return them
			if (want.cmd == fbpa_pkg::CMD_ALLOC && want.status == fbpa_pkg::STS_OK &&
					handed_out.size() < 64)
				handed_out = {handed_out, want.addr};
		endtask
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             psel = 1'b0;
	logic                             penable = 1'b0;
	logic                             pwrite = 1'b0;
	logic [fbpa_pkg::APB_AW-1:0]      paddr = '0;
	logic [31:0]                      pwdata = '0;
	logic [31:0]                      prdata;
	logic                             pready;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [31:0]                      s_tdata = '0;
	logic [fbpa_pkg::CMD_W-1:0]       s_tuser = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [fbpa_pkg::M_TDATA_W-1:0]   m_tdata;
	logic [fbpa_pkg::STATUS_W-1:0]    m_tuser;

	bit                     quiet = 1'b0;
	int                     idle_cycles = 0;
	block_pool_mirror       mirror;

	fixed_block_pool_allocator #(
		.MAX_BLOCKS(POOL_DEPTH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				mirror.take_command(fbpa_pkg::cmd_t'(s_tuser), s_tdata);
			if (m_tvalid && m_tready)
				mirror.match_result(m_tuser, m_tdata);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side back-pressure
	initial begin
		forever begin
			int g;
			int h;
			g = gap_len();
			if (g > 0) begin
				@(negedge clk) m_tready <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end
			h = $urandom_range(1, 8);
			@(negedge clk) m_tready <= 1'b1;
			repeat (h - 1) @(negedge clk);
		end
	end

	task automatic put_reg(fbpa_pkg::reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk) penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready)
				break;
		end
		mirror.write_reg(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// drop valid and wait until every result is back
	task automatic settle();
		@(negedge clk) s_tvalid <= 1'b0;
		while (mirror.pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic configure(logic [31:0] base, logic [31:0] bytes,
			logic [31:0] blk, logic [31:0] align);
		settle();
		put_reg(fbpa_pkg::REG_CHUNK_BASE, base);
		put_reg(fbpa_pkg::REG_CHUNK_BYTES, bytes);
		put_reg(fbpa_pkg::REG_BLOCK_BYTES, blk);
		put_reg(fbpa_pkg::REG_ALIGNMENT, align);
	endtask

	task automatic send_cmd(fbpa_pkg::cmd_t cmd, logic [31:0] addr);
		int g;
		g = gap_len();
		if (g > 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= addr;
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
	endtask

	function automatic logic [31:0] pick_alignment();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 25)
			return fbpa_pkg::ALIGN_ODD;
		if (r < 85)
			return 32'd1 << $urandom_range(0, 31);
		// at least two bits set, never a power of two
		return $urandom | 32'h3;
	endfunction

	task automatic random_items(int count, int alloc_pct);
		int          r;
		int          r2;
		int          pick;
		logic [31:0] off;
		logic [31:0] addr;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				send_cmd(fbpa_pkg::CMD_RSVD, $urandom);
			end else if (r < 3) begin
				send_cmd(fbpa_pkg::CMD_INIT, $urandom);
			end else if (r < 3 + alloc_pct * 97 / 100) begin
				send_cmd(fbpa_pkg::CMD_ALLOC, $urandom);
			end else begin
				r2 = $urandom_range(0, 99);
				if (r2 < 30 && mirror.handed_out.size() > 0) begin
					pick = $urandom_range(0, mirror.handed_out.size() - 1);
					addr = mirror.handed_out[pick];
					mirror.handed_out.delete(pick);
				end else if (r2 < 75) begin
					off = (mirror.chunk_bytes == '0) ? '0 : $urandom % mirror.chunk_bytes;
					if (r2[0] && mirror.block_bytes != '0)
						off = off - (off % mirror.block_bytes);
					addr = mirror.chunk_base + off;
				end else begin
					addr = $urandom;
				end
				send_cmd(fbpa_pkg::CMD_FREE, addr);
			end
		end
	endtask

	initial begin
		int          pct;
		logic [31:0] blk;
		mirror = new();
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// no pool yet, unknown command, all-zero registers
		send_cmd(fbpa_pkg::CMD_ALLOC, 32'h0);
		send_cmd(fbpa_pkg::CMD_FREE, 32'hFFFF_FFFF);
		send_cmd(fbpa_pkg::CMD_RSVD, 32'hFFFF_FFFF);
		send_cmd(fbpa_pkg::CMD_INIT, 32'h0);
		// block bigger than the chunk
		configure(32'h0, 32'd8, 32'd16, 32'h0);
		send_cmd(fbpa_pkg::CMD_INIT, 32'h0);
		// base not 8-aligned
		configure(32'h1004, 32'd64, 32'd16, 32'h0);
		send_cmd(fbpa_pkg::CMD_INIT, 32'h0);
		// alignment not a power of two
		configure(32'h1000, 32'd64, 32'd16, 32'd3);
		send_cmd(fbpa_pkg::CMD_INIT, 32'h0);
		// alignment of two read as four, four blocks, drain past empty
		configure(32'h1000, 32'd64, 32'd16, fbpa_pkg::ALIGN_ODD);
		send_cmd(fbpa_pkg::CMD_INIT, 32'h0);
		repeat (5) send_cmd(fbpa_pkg::CMD_ALLOC, 32'h0);
		// range edges: one below base, one past the end, last byte, base
		send_cmd(fbpa_pkg::CMD_FREE, 32'h0FFF);
		send_cmd(fbpa_pkg::CMD_FREE, 32'h1040);
		send_cmd(fbpa_pkg::CMD_FREE, 32'h103F);
		send_cmd(fbpa_pkg::CMD_FREE, 32'h1000);
		send_cmd(fbpa_pkg::CMD_RSVD, 32'h5555_AAAA);
		send_cmd(fbpa_pkg::CMD_ALLOC, 32'h0);
		configure(32'h1000, 32'd64, 32'd16, 32'hFFFF_FFFF);
		send_cmd(fbpa_pkg::CMD_INIT, 32'h0);
		configure(32'h1000, 32'd64, 32'd16, 32'h8000_0000);
		send_cmd(fbpa_pkg::CMD_INIT, 32'h0);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				// top of the address space, fill wraps past zero
				0: configure(32'hFFFF_FFF8, 32'hFFFF_FFFF, 32'h0040_0000, 32'd8);
				// more blocks than the stack holds
				3: configure(32'h0, 32'hFFFF_FFFF, 32'd1, 32'h0);
				// one block spanning the whole chunk
				6: configure(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
				// failing init keeps the old pool
				8: configure(32'h3, 32'd100, 32'd4, 32'd4);
				default: begin
					blk = $urandom_range(1, 64);
					configure($urandom & ~32'h7,
						blk * $urandom_range(1, 40) + $urandom_range(0, blk - 1),
						blk, pick_alignment());
				end
			endcase
			quiet = (ph % 4 == 2);
			send_cmd(fbpa_pkg::CMD_INIT, $urandom);
			case ($urandom_range(0, 2))
				0: pct = 20;
				1: pct = 50;
				default: pct = 80;
			endcase
			if (ph == 3 || ph == 6)
				pct = 20;
			random_items(PHASE_ITEMS, pct);
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_ram.sv
rtl/core/fixed_block_pool_allocator.sv
tb/fixed_block_pool_allocator_tb.sv
